// File: design/srs_pkg.sv
// Shared types and constants for the streaming substring replacer.
// Used by srs_config, srs_window, srs_burst and substring_replace_stream.
`default_nettype none

package srs_pkg;

	localparam int BYTE_W          = 8;
	localparam int MAX_PATTERN     = 8;
	localparam int MAX_REPLACEMENT = 8;
	localparam int WIN_DEPTH       = 8;
	localparam int CFG_W           = 64;
	localparam int LEN_W           = 4;
	localparam int FILL_W          = 3;
	localparam int IDX_W           = 3;
	localparam int CNT_W           = 4;
	localparam int REG_IDX_W       = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} reg_index_t;

	// Configuration with both lengths already limited to their maxima.
	typedef struct packed {
		logic [MAX_PATTERN*BYTE_W-1:0]     pattern;
		logic [LEN_W-1:0]                  plen;
		logic [MAX_REPLACEMENT*BYTE_W-1:0] repl;
		logic [LEN_W-1:0]                  rlen;
	} cfg_t;

	// All results caused by one input item.
	typedef struct packed {
		logic [WIN_DEPTH-1:0][BYTE_W-1:0] data;
		logic [CNT_W-1:0]                 count;
		logic                             valid;
		logic                             fin;
	} burst_t;

	typedef struct packed {
		logic busy;
		logic last_take;
	} burst_status_t;

endpackage

`default_nettype wire

// File: design/substring_replace_stream.sv
// Streaming substring replacer: an item is registered, matched against the window in
// one pass, and its burst of up to eight results sent one per cycle while m_tready is high.
// The first result of an item is offered after it passes the item and result registers.
// One item per cycle unless an item with results waits for a busy result register.
// Reset: asynchronous; clears the configuration, the window fill and all valid flags.
// Depends on srs_pkg, srs_config, srs_window and srs_burst.
`default_nettype none

module substring_replace_stream (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [srs_pkg::BYTE_W-1:0]    s_tdata,   // in_byte
	input  wire logic                          s_tlast,   // in_final
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [srs_pkg::BYTE_W-1:0]         m_tdata,   // out_byte
	output logic [1:0]                         m_tuser,   // stream_end (bit 1), out_valid (bit 0)
	output logic                               m_tlast,   // run_end
	input  wire logic                          cfg_we,
	input  wire logic [srs_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [srs_pkg::CFG_W-1:0]     cfg_data
);

	srs_pkg::cfg_t          cfg;
	srs_pkg::burst_t        burst_d;
	srs_pkg::burst_status_t status;

	logic                       valid_s1;
	logic [srs_pkg::BYTE_W-1:0] byte_s1;
	logic                       final_s1;
	logic                       advance;
	logic                       load;

	// Items with no result never wait for the result register.
	assign advance  = valid_s1 & ((burst_d.count == '0) | ~status.busy | status.last_take);
	assign load     = advance & (burst_d.count != '0);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			final_s1 <= s_tlast;
		end
	end

	srs_config u_config (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	srs_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_byte  (byte_s1),
		.item_final (final_s1),
		.advance    (advance),
		.burst_d    (burst_d)
	);

	srs_burst u_burst (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.burst_d  (burst_d),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.status   (status)
	);

endmodule

`default_nettype wire

// File: design/srs_config.sv
// Configuration registers of the substring replacer, with length limiting.
// Depends on srs_pkg.
`default_nettype none

module srs_config (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [srs_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire logic [srs_pkg::CFG_W-1:0]       cfg_data,
	output srs_pkg::cfg_t                        cfg
);

	logic [srs_pkg::MAX_PATTERN*srs_pkg::BYTE_W-1:0]     pattern_q;
	logic [srs_pkg::LEN_W-1:0]                           plen_q;
	logic [srs_pkg::MAX_REPLACEMENT*srs_pkg::BYTE_W-1:0] repl_q;
	logic [srs_pkg::LEN_W-1:0]                           rlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= '0;
			repl_q    <= '0;
			rlen_q    <= '0;
		end else if (cfg_we) begin
			unique case (srs_pkg::reg_index_t'(cfg_index))
				srs_pkg::REG_PATTERN_BYTES:
					pattern_q <= cfg_data[srs_pkg::MAX_PATTERN*srs_pkg::BYTE_W-1:0];
				srs_pkg::REG_PATTERN_LENGTH:     plen_q <= cfg_data[srs_pkg::LEN_W-1:0];
				srs_pkg::REG_REPLACEMENT_BYTES:
					repl_q <= cfg_data[srs_pkg::MAX_REPLACEMENT*srs_pkg::BYTE_W-1:0];
				srs_pkg::REG_REPLACEMENT_LENGTH: rlen_q <= cfg_data[srs_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.pattern = pattern_q;
		cfg.repl    = repl_q;
		cfg.plen    = (plen_q > srs_pkg::LEN_W'(srs_pkg::MAX_PATTERN)) ?
		              srs_pkg::LEN_W'(srs_pkg::MAX_PATTERN) : plen_q;
		cfg.rlen    = (rlen_q > srs_pkg::LEN_W'(srs_pkg::MAX_REPLACEMENT)) ?
		              srs_pkg::LEN_W'(srs_pkg::MAX_REPLACEMENT) : rlen_q;
	end

endmodule

`default_nettype wire

// File: design/srs_window.sv
// Match window: holds the bytes not yet emitted and works out the result burst
// of the registered item in one pass. Depends on srs_pkg.
`default_nettype none

module srs_window (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire srs_pkg::cfg_t                cfg,
	input  wire logic [srs_pkg::BYTE_W-1:0]   item_byte,
	input  wire logic                         item_final,
	input  wire logic                         advance,
	output srs_pkg::burst_t                   burst_d
);

	logic [srs_pkg::BYTE_W-1:0] win_q [srs_pkg::WIN_DEPTH];
	logic [srs_pkg::FILL_W-1:0] fill_q;

	logic [srs_pkg::BYTE_W-1:0] win_add [srs_pkg::WIN_DEPTH];
	logic [srs_pkg::BYTE_W-1:0] win_nxt [srs_pkg::WIN_DEPTH];
	logic [srs_pkg::CNT_W-1:0]  fill_add;
	logic [srs_pkg::FILL_W-1:0] fill_nxt;
	logic                       hit;
	logic                       pass;
	logic                       at_len;
	logic                       use_repl;
	logic [srs_pkg::CNT_W-1:0]  count;

	always_comb begin
		fill_add = {1'b0, fill_q} + srs_pkg::CNT_W'(1);
		for (int i = 0; i < srs_pkg::WIN_DEPTH; i++) begin
			win_add[i] = (fill_q == srs_pkg::FILL_W'(i)) ? item_byte : win_q[i];
		end

		hit = 1'b1;
		for (int i = 0; i < srs_pkg::MAX_PATTERN; i++) begin
			if (srs_pkg::LEN_W'(i) < cfg.plen &&
			    win_add[i] != cfg.pattern[i*srs_pkg::BYTE_W +: srs_pkg::BYTE_W]) begin
				hit = 1'b0;
			end
		end

		// A shrunk pattern leaves more bytes than it can match: flush them all.
		pass   = (cfg.plen == '0) || (fill_add > cfg.plen);
		at_len = (fill_add == cfg.plen);

		use_repl = 1'b0;
		for (int i = 0; i < srs_pkg::WIN_DEPTH; i++) win_nxt[i] = win_add[i];
		if (pass) begin
			count    = fill_add;
			fill_nxt = '0;
		end else if (at_len && hit) begin
			use_repl = 1'b1;
			count    = cfg.rlen;
			fill_nxt = '0;
		end else if (at_len) begin
			// Miss: the oldest byte leaves, the final byte flushes the rest.
			count    = item_final ? fill_add : srs_pkg::CNT_W'(1);
			fill_nxt = item_final ? '0 : fill_q;
			for (int i = 0; i < srs_pkg::WIN_DEPTH - 1; i++) win_nxt[i] = win_add[i+1];
		end else begin
			count    = item_final ? fill_add : '0;
			fill_nxt = item_final ? '0 : fill_add[srs_pkg::FILL_W-1:0];
		end

		burst_d.fin   = item_final;
		burst_d.valid = 1'b1;
		for (int i = 0; i < srs_pkg::WIN_DEPTH; i++) begin
			burst_d.data[i] = use_repl ?
			                  cfg.repl[i*srs_pkg::BYTE_W +: srs_pkg::BYTE_W] : win_add[i];
		end
		burst_d.count = count;
		// A final item that emits nothing still yields one empty end marker.
		if (item_final && count == '0) begin
			burst_d.count   = srs_pkg::CNT_W'(1);
			burst_d.valid   = 1'b0;
			burst_d.data[0] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (advance) begin
			fill_q <= fill_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < srs_pkg::WIN_DEPTH; i++) win_q[i] <= win_nxt[i];
		end
	end

endmodule

`default_nettype wire

// File: design/srs_burst.sv
// Result register: holds one item's burst and sends it out one result per cycle while m_tready is high.
// Depends on srs_pkg.
`default_nettype none

module srs_burst (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire srs_pkg::burst_t             burst_d,
	input  wire logic                        m_tready,
	output logic                             m_tvalid,
	output logic [srs_pkg::BYTE_W-1:0]       m_tdata,  // out_byte
	output logic [1:0]                       m_tuser,  // stream_end (bit 1), out_valid (bit 0)
	output logic                             m_tlast,  // run_end
	output srs_pkg::burst_status_t           status
);

	srs_pkg::burst_t           bst_s2;
	logic                      busy_q;
	logic [srs_pkg::IDX_W-1:0] idx_q;
	logic                      last_beat;

	assign last_beat = ({1'b0, idx_q} == bst_s2.count - srs_pkg::CNT_W'(1));

	assign m_tvalid         = busy_q;
	assign m_tdata          = bst_s2.data[idx_q];
	assign m_tuser          = {bst_s2.fin & last_beat, bst_s2.valid};
	assign m_tlast          = last_beat;
	assign status.busy      = busy_q;
	assign status.last_take = busy_q & m_tready & last_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && m_tready) begin
			if (last_beat) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + srs_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bst_s2 <= burst_d;
		end
	end

endmodule

`default_nettype wire

// File: dv/tb_substring_replace_stream.sv
// Self-checking testbench for substring_replace_stream. It drives byte texts through
// the stream input, predicts every output item from its own copy of the window and the
// registers, and checks each item. Depends on srs_pkg and the design sources.
`timescale 1ns / 100ps

module tb_substring_replace_stream;

	localparam int IDLE_LIMIT    = 3000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_TEXTS  = 12;
	localparam int TEXT_BYTES    = 35;

	localparam int RDY_ALWAYS  = 0;
	localparam int RDY_MOSTLY  = 1;
	localparam int RDY_SPARSE  = 2;
	localparam int RDY_PATTERN = 3;

	typedef struct packed {
		logic [srs_pkg::BYTE_W-1:0] data;
		logic                       fin;
	} text_item_t;

	typedef struct packed {
		logic [srs_pkg::BYTE_W-1:0] data;
		logic                       valid;
		logic                       run_end;
		logic                       stream_end;
	} out_item_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [srs_pkg::BYTE_W-1:0]    s_tdata = '0;
	logic                          s_tlast = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [srs_pkg::BYTE_W-1:0]    m_tdata;
	logic [1:0]                    m_tuser;
	logic                          m_tlast;
	logic                          cfg_we = 1'b0;
	logic [srs_pkg::REG_IDX_W-1:0] cfg_index = '0;
	logic [srs_pkg::CFG_W-1:0]     cfg_data = '0;

	substring_replace_stream u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Shadow of the registers and of the unemitted window.
	logic [srs_pkg::CFG_W-1:0]  pat_reg = '0;
	logic [srs_pkg::LEN_W-1:0]  pat_len_reg = '0;
	logic [srs_pkg::CFG_W-1:0]  rep_reg = '0;
	logic [srs_pkg::LEN_W-1:0]  rep_len_reg = '0;
	logic [srs_pkg::BYTE_W-1:0] win_buf [srs_pkg::WIN_DEPTH];
	int                         win_fill = 0;

	text_item_t text_q [$];
	out_item_t  out_expect_q [$];
	out_item_t  step_q [$];
	logic [srs_pkg::BYTE_W-1:0] alpha [3];

	int err_cnt = 0;
	int items_in = 0;
	int items_out = 0;
	int texts_done = 0;
	int configs_used = 0;
	int idle_cycles = 0;

	initial begin
		for (int i = 0; i < srs_pkg::WIN_DEPTH; i++)
			win_buf[i] = '0;
	end

	function automatic int clamp8(input logic [srs_pkg::LEN_W-1:0] len);
		return (len > 8) ? 8 : int'(len);
	endfunction

	function automatic out_item_t make_out(input logic [srs_pkg::BYTE_W-1:0] data,
		input logic valid);
		out_item_t o;
		o.data = data;
		o.valid = valid;
		o.run_end = 1'b0;
		o.stream_end = 1'b0;
		return o;
	endfunction

	task automatic flush_window();
		for (int i = 0; i < win_fill && i < srs_pkg::WIN_DEPTH; i++)
			step_q.push_back(make_out(win_buf[i], 1'b1));
		win_fill = 0;
	endtask

	// Works out the output items caused by one accepted text byte.
	task automatic replace_step(input logic [srs_pkg::BYTE_W-1:0] in_byte,
		input logic in_final);
		int plen;
		int rlen;
		bit hit;
		out_item_t tail;
		plen = clamp8(pat_len_reg);
		rlen = clamp8(rep_len_reg);
		step_q.delete();
		if (win_fill >= srs_pkg::WIN_DEPTH)
			flush_window();
		win_buf[win_fill % srs_pkg::WIN_DEPTH] = in_byte;
		win_fill++;
		if (plen == 0 || win_fill > plen) begin
			flush_window();
		end else if (win_fill == plen) begin
			hit = 1'b1;
			for (int i = 0; i < plen; i++)
				if (win_buf[i] != pat_reg[8*i +: 8])
					hit = 1'b0;
			if (hit) begin
				for (int i = 0; i < rlen; i++)
					step_q.push_back(make_out(rep_reg[8*i +: 8], 1'b1));
				win_fill = 0;
			end else begin
				step_q.push_back(make_out(win_buf[0], 1'b1));
				for (int i = 1; i < srs_pkg::WIN_DEPTH; i++)
					win_buf[i-1] = win_buf[i];
				win_fill--;
			end
		end
		if (in_final) begin
			flush_window();
			// An empty end marker closes a text that left nothing to emit.
			if (step_q.size() == 0)
				step_q.push_back(make_out('0, 1'b0));
			tail = step_q.pop_back();
			tail.stream_end = 1'b1;
			step_q.push_back(tail);
		end
		if (step_q.size() > 0) begin
			tail = step_q.pop_back();
			tail.run_end = 1'b1;
			step_q.push_back(tail);
		end
		foreach (step_q[i])
			out_expect_q.push_back(step_q[i]);
	endtask

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	text_item_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				replace_step(s_tdata, s_tlast);
				items_in++;
				if (s_tlast)
					texts_done++;
			end
			if (!s_tvalid || s_tready) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (text_q.size() > 0) begin
					next_item = text_q.pop_front();
					s_tdata <= next_item.data;
					s_tlast <= next_item.fin;
					s_tvalid <= 1'b1;
					burst_left--;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: ready follows a mode that is chosen anew at random whenever its run ends.
	int ready_mode = RDY_ALWAYS;
	int mode_left = 0;
	logic [7:0] ready_mask = 8'h01;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			mode_left = 0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(RDY_ALWAYS, RDY_PATTERN);
				mode_left = $urandom_range(20, 150);
				ready_mask = 8'($urandom) | 8'h01;
			end
			mode_left--;
			case (ready_mode)
				RDY_ALWAYS: m_tready <= 1'b1;
				RDY_MOSTLY: m_tready <= ($urandom_range(0, 9) < 7);
				RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default: begin
					m_tready <= ready_mask[0];
					ready_mask = {ready_mask[0], ready_mask[7:1]};
				end
			endcase
		end
	end

	// Checker for every accepted output item.
	out_item_t got_item;
	out_item_t want_item;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			items_out++;
			got_item.data = m_tdata;
			got_item.valid = m_tuser[0];
			got_item.run_end = m_tlast;
			got_item.stream_end = m_tuser[1];
			if (out_expect_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected output item: expected none, got %h/%b/%b/%b",
					$time, got_item.data, got_item.valid, got_item.run_end,
					got_item.stream_end);
			end else begin
				want_item = out_expect_q.pop_front();
				if (got_item !== want_item) begin
					err_cnt++;
					$display("%0t: output mismatch (byte/valid/run/stream): %s %h/%b/%b/%b",
						$time, "expected", want_item.data, want_item.valid,
						want_item.run_end, want_item.stream_end);
					$display("%0t: output mismatch (byte/valid/run/stream): %s %h/%b/%b/%b",
						$time, "actual  ", got_item.data, got_item.valid,
						got_item.run_end, got_item.stream_end);
				end
			end
		end
	end

	// Watchdog on cycles in which neither side moves an item.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout, %0d output items still awaited", $time,
				out_expect_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(input srs_pkg::reg_index_t idx,
		input logic [srs_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			srs_pkg::REG_PATTERN_BYTES:     pat_reg = value;
			srs_pkg::REG_PATTERN_LENGTH:    pat_len_reg = value[srs_pkg::LEN_W-1:0];
			srs_pkg::REG_REPLACEMENT_BYTES: rep_reg = value;
			default:                        rep_len_reg = value[srs_pkg::LEN_W-1:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Length registers get random upper bits; only the low nibble is kept.
	task automatic write_len(input srs_pkg::reg_index_t idx, input int len);
		logic [srs_pkg::CFG_W-1:0] value;
		value = {$urandom, $urandom};
		value[srs_pkg::LEN_W-1:0] = len[srs_pkg::LEN_W-1:0];
		write_reg(idx, value);
	endtask

	task automatic queue_byte(input logic [srs_pkg::BYTE_W-1:0] data, input logic fin);
		text_item_t t;
		t.data = data;
		t.fin = fin;
		text_q.push_back(t);
	endtask

	// Waits until every byte is sent and every output item has arrived, then lets
	// the pipeline settle so that items with no output are finished too.
	task automatic wait_idle();
		@(posedge clk);
		while (text_q.size() != 0 || s_tvalid || out_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly copies and broken prefixes of the pattern over a small alphabet,
	// with some fully random bytes as noise.
	task automatic gen_text(input int n);
		logic [srs_pkg::BYTE_W-1:0] seq [$];
		int plen;
		int choice;
		int cut;
		plen = clamp8(pat_len_reg);
		while (seq.size() < n) begin
			choice = $urandom_range(0, 9);
			if (choice <= 4) begin
				for (int k = 0; k < plen; k++)
					seq.push_back(pat_reg[8*k +: 8]);
			end else if (choice <= 6) begin
				cut = $urandom_range(1, (plen > 1) ? plen - 1 : 1);
				for (int k = 0; k < cut && k < plen; k++)
					seq.push_back(pat_reg[8*k +: 8]);
				seq.push_back(alpha[$urandom_range(0, 2)]);
			end else if (choice <= 8) begin
				seq.push_back(alpha[$urandom_range(0, 2)]);
			end else begin
				seq.push_back(8'($urandom));
			end
		end
		for (int k = 0; k < seq.size(); k++) begin
			if (k == seq.size() - 1)
				queue_byte(seq[k], $urandom_range(0, 3) != 0);
			else
				queue_byte(seq[k], $urandom_range(0, 24) == 0);
		end
	endtask

	initial begin
		logic [srs_pkg::CFG_W-1:0] word;
		int len;
		int choice;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Registers at reset: bytes pass straight through.
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b1);
		wait_idle();

		// "ab" becomes "XYZ": a failed start, a hit, and a final byte that flushes.
		write_reg(srs_pkg::REG_PATTERN_BYTES, 64'h6261);
		write_len(srs_pkg::REG_PATTERN_LENGTH, 2);
		write_reg(srs_pkg::REG_REPLACEMENT_BYTES, 64'h5A5958);
		write_len(srs_pkg::REG_REPLACEMENT_LENGTH, 3);
		configs_used++;
		queue_byte("a", 1'b0);
		queue_byte("a", 1'b0);
		queue_byte("b", 1'b0);
		queue_byte("c", 1'b0);
		queue_byte("a", 1'b1);
		queue_byte("a", 1'b0);
		queue_byte("b", 1'b1);
		wait_idle();

		// Deleting the replacement leaves a text with nothing to emit: empty end marker.
		write_len(srs_pkg::REG_REPLACEMENT_LENGTH, 0);
		configs_used++;
		queue_byte("a", 1'b0);
		queue_byte("b", 1'b1);
		wait_idle();

		// Lengths above the maximum count as eight; all-ones pattern, all-zero replacement.
		write_reg(srs_pkg::REG_PATTERN_BYTES, '1);
		write_len(srs_pkg::REG_PATTERN_LENGTH, 15);
		write_reg(srs_pkg::REG_REPLACEMENT_BYTES, '0);
		write_len(srs_pkg::REG_REPLACEMENT_LENGTH, 12);
		configs_used++;
		repeat (8) queue_byte(8'hFF, 1'b0);
		// Leave three bytes waiting, then shrink the pattern under them.
		repeat (3) queue_byte(8'hFF, 1'b0);
		wait_idle();
		write_len(srs_pkg::REG_PATTERN_LENGTH, 1);
		configs_used++;
		queue_byte(8'h00, 1'b1);
		wait_idle();

		for (int ph = 0; ph < RANDOM_TEXTS; ph++) begin
			for (int k = 0; k < 3; k++)
				alpha[k] = 8'($urandom);
			choice = $urandom_range(0, 9);
			if (choice == 0)
				len = 0;
			else if (choice == 1)
				len = $urandom_range(9, 15);
			else
				len = $urandom_range(1, 8);
			for (int k = 0; k < 8; k++)
				word[8*k +: 8] = (k < clamp8(len[srs_pkg::LEN_W-1:0])) ?
					alpha[$urandom_range(0, 2)] : 8'($urandom);
			write_reg(srs_pkg::REG_PATTERN_BYTES, word);
			write_len(srs_pkg::REG_PATTERN_LENGTH, len);
			write_reg(srs_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
			write_len(srs_pkg::REG_REPLACEMENT_LENGTH,
				($urandom_range(0, 5) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8));
			configs_used++;
			gen_text(TEXT_BYTES);
			wait_idle();
		end

		$display("Sent %0d text bytes in %0d completed texts under %0d register settings.",
			items_in, texts_done, configs_used);
		$display("Checked %0d output items, %0d of them wrong or unexpected.",
			items_out, err_cnt);
		if (err_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: substring_replace_stream.f
design/srs_pkg.sv
design/srs_config.sv
design/srs_window.sv
design/srs_burst.sv
design/substring_replace_stream.sv
dv/tb_substring_replace_stream.sv
